@@ rtl/core/priority_process_scheduler_macros.svh @@
// assertion macros for the priority process scheduler
// expects signals named clk and rst_n in the including module
`ifndef PRIORITY_PROCESS_SCHEDULER_MACROS_SVH
`define PRIORITY_PROCESS_SCHEDULER_MACROS_SVH

// same-cycle implication
`define PPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pps assertion failed");

// next-cycle implication
`define PPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pps assertion failed");

`endif

@@ rtl/core/pps_pkg.sv @@
// shared constants and types for the priority process scheduler
// no dependencies
package pps_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int TIME_W    = 32;
    localparam int IN_SLOT_W = 4;
    localparam int PRIO_W    = 8;
    localparam int WORK_W    = 16;
    localparam int WAIT_W    = 32;
    localparam int OUT_W     = 32;

    // candidate handed from cell to cell during a scan
    typedef struct packed {
        logic              found;
        logic [PRIO_W-1:0] prio;
        logic [SLOT_W-1:0] idx;
    } cand_t;

    // broadcast command to every cell
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic [PRIO_W-1:0] wr_prio;
        logic [WORK_W-1:0] wr_burst;
        logic              run_en;
        logic [SLOT_W-1:0] cur_slot;
    } cell_cmd_t;

    // status of the current slot, zero from every other cell
    typedef struct packed {
        logic              live;
        logic              last;
        logic [WAIT_W-1:0] wait_cnt;
        logic [WORK_W-1:0] burst;
    } cell_stat_t;

endpackage

@@ rtl/core/priority_process_scheduler.sv @@
// Priority process scheduler over a row of process-slot cells. An arrival (tuser 0)
// loads a slot; a tick (tuser 1) runs the current process for one time unit and
// returns one result transaction. When no live process is current at a tick, or an
// arrival comes while preemption is on, a candidate travels down the row one cell
// per clock and is then latched as the current process. An arrival returns no
// result. Input is taken again as soon as the result is in the output register,
// even if it has not yet been taken downstream.
// depends on pps_pkg, pps_cell and priority_process_scheduler_macros.svh
`include "priority_process_scheduler_macros.svh"

module priority_process_scheduler
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,   // preempt_mode
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,       // slot[3:0], priority_req[11:4], burst_length[27:12], zero
    input  logic [0:0]   s_tuser,       // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,       // running_slot[3:0], finish_time[35:4], waited[67:36],
                                        // turnaround[99:68], zero
    output logic [1:0]   m_tuser        // ran, completed
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_PICK = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef struct packed {
        logic                          ran;
        logic                          completed;
        logic [pps_pkg::IN_SLOT_W-1:0] slot;
        logic [pps_pkg::OUT_W-1:0]     fin;
        logic [pps_pkg::OUT_W-1:0]     waited;
        logic [pps_pkg::OUT_W-1:0]     ta;
    } res_t;

    logic [2:0]                     state_reg, state_next;
    logic [pps_pkg::SLOT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                           is_tick_reg, is_tick_next;
    logic                           preempt_reg;
    logic [pps_pkg::SLOT_W-1:0]     cur_slot_reg, cur_slot_next;
    logic                           cur_valid_reg, cur_valid_next;
    logic [pps_pkg::TIME_W-1:0]     time_reg, time_next;
    res_t                           res_reg, res_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    res_t                           out_reg, out_next;

    pps_pkg::cell_cmd_t             cmd;
    pps_pkg::cand_t                 cand [pps_pkg::NUM_SLOTS+1];
    pps_pkg::cell_stat_t            stat [pps_pkg::NUM_SLOTS];
    pps_pkg::cell_stat_t            cur_bus;

    logic                           in_fire;
    logic                           arrive_ok;
    logic                           out_free;
    logic [pps_pkg::IN_SLOT_W-1:0]  in_slot;
    logic [pps_pkg::TIME_W-1:0]     time_inc;
    logic [pps_pkg::WAIT_W:0]       ta_sum;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign in_slot   = s_tdata[3:0];
    assign arrive_ok = (32'(in_slot) < pps_pkg::NUM_SLOTS);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign cmd.wr_en    = in_fire && (s_tuser[0] == FUNC_ARRIVE) && arrive_ok;
    assign cmd.wr_slot  = pps_pkg::SLOT_W'(in_slot);
    assign cmd.wr_prio  = s_tdata[11:4];
    assign cmd.wr_burst = s_tdata[27:12];
    assign cmd.run_en   = (state_reg == ST_RUN) && cur_valid_reg;
    assign cmd.cur_slot = cur_slot_reg;

    assign cand[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < pps_pkg::NUM_SLOTS; gi++)
        begin : g_cell
            pps_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .idx      (pps_pkg::SLOT_W'(gi)),
                .cmd      (cmd),
                .cand_in  (cand[gi]),
                .cand_out (cand[gi+1]),
                .stat     (stat[gi])
            );
        end
    endgenerate

    always_comb
    begin
        cur_bus = '0;
        for (int i = 0; i < pps_pkg::NUM_SLOTS; i++)
        begin
            cur_bus = cur_bus | stat[i];
        end
    end

    assign time_inc = (time_reg != '1) ? time_reg + 1'b1 : time_reg;
    assign ta_sum   = {1'b0, cur_bus.wait_cnt} + (pps_pkg::WAIT_W+1)'(cur_bus.burst);

    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        is_tick_next   = is_tick_reg;
        cur_slot_next  = cur_slot_reg;
        cur_valid_next = cur_valid_reg;
        time_next      = time_reg;
        res_next       = res_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_next       = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    scan_cnt_next = '0;
                    if (s_tuser[0] == FUNC_TICK)
                    begin
                        is_tick_next = 1'b1;
                        state_next   = (cur_valid_reg && cur_bus.live) ? ST_RUN : ST_SCAN;
                    end
                    else
                    begin
                        is_tick_next = 1'b0;
                        if (arrive_ok && preempt_reg)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == pps_pkg::SLOT_W'(pps_pkg::NUM_SLOTS - 1))
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                cur_valid_next = cand[pps_pkg::NUM_SLOTS].found;
                cur_slot_next  = cand[pps_pkg::NUM_SLOTS].found ?
                                 cand[pps_pkg::NUM_SLOTS].idx : '0;
                state_next     = is_tick_reg ? ST_RUN : ST_IDLE;
            end
            ST_RUN:
            begin
                time_next = time_inc;
                res_next  = '0;
                if (cur_valid_reg)
                begin
                    res_next.ran  = 1'b1;
                    res_next.slot = pps_pkg::IN_SLOT_W'(cur_slot_reg);
                    if (cur_bus.last)
                    begin
                        res_next.completed = 1'b1;
                        res_next.waited    = pps_pkg::OUT_W'(cur_bus.wait_cnt);
                        res_next.ta        = ta_sum[pps_pkg::WAIT_W] ? '1 :
                                             pps_pkg::OUT_W'(ta_sum);
                        if ({{pps_pkg::OUT_W{1'b0}}, time_inc} >
                            {{pps_pkg::TIME_W{1'b0}}, {pps_pkg::OUT_W{1'b1}}})
                        begin
                            res_next.fin = '1;
                        end
                        else
                        begin
                            res_next.fin = pps_pkg::OUT_W'(time_inc);
                        end
                        cur_valid_next = 1'b0;
                    end
                end
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            is_tick_reg   <= 1'b0;
            preempt_reg   <= 1'b1;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            time_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            is_tick_reg   <= is_tick_next;
            cur_slot_reg  <= cur_slot_next;
            cur_valid_reg <= cur_valid_next;
            time_reg      <= time_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                preempt_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {out_reg.completed, out_reg.ran};
    assign m_tdata  = {4'b0000, out_reg.ta, out_reg.waited, out_reg.fin, out_reg.slot};

    `PPS_ASSERT_NOW(a_completed_ran, m_tvalid && m_tuser[1], m_tuser[0])
    `PPS_ASSERT_NOW(a_idle_tick_zero, m_tvalid && !m_tuser[0], m_tdata == '0)
    `PPS_ASSERT_NEXT(a_done_clears_cur, (state_reg == ST_RUN) && cur_valid_reg && cur_bus.last, !cur_valid_reg)
    `PPS_ASSERT_NEXT(a_push_delivers, (state_reg == ST_PUSH) && out_free, m_tvalid && (state_reg == ST_IDLE))

endmodule

@@ rtl/core/pps_cell.sv @@
// one process slot of the scheduler row with its share of the priority scan
// depends on pps_pkg
module pps_cell
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [pps_pkg::SLOT_W-1:0]      idx,
    input  pps_pkg::cell_cmd_t              cmd,
    input  pps_pkg::cand_t                  cand_in,
    output pps_pkg::cand_t                  cand_out,
    output pps_pkg::cell_stat_t             stat
);

    logic                          valid_reg;
    logic [pps_pkg::PRIO_W-1:0]    prio_reg;
    logic [pps_pkg::WORK_W-1:0]    rem_reg;
    logic [pps_pkg::WORK_W-1:0]    burst_reg;
    logic [pps_pkg::WAIT_W-1:0]    wait_reg;
    pps_pkg::cand_t                cand_reg;
    pps_pkg::cand_t                cand_next;
    logic                          live;
    logic                          is_cur;
    logic                          wr_hit;

    assign live   = valid_reg && (rem_reg != '0);
    assign is_cur = (cmd.cur_slot == idx);
    assign wr_hit = cmd.wr_en && (cmd.wr_slot == idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cand_reg  <= '0;
        end
        else
        begin
            if (wr_hit)
            begin
                valid_reg <= 1'b1;
            end
            cand_reg <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            prio_reg  <= cmd.wr_prio;
            rem_reg   <= cmd.wr_burst;
            burst_reg <= cmd.wr_burst;
            wait_reg  <= '0;
        end
        else if (cmd.run_en)
        begin
            if (is_cur)
            begin
                rem_reg <= rem_reg - 1'b1;
            end
            else if (live && (wait_reg != '1))
            begin
                wait_reg <= wait_reg + 1'b1;
            end
        end
    end

    // later cells replace the candidate only on strictly higher priority
    always_comb
    begin
        cand_next = cand_in;
        if (live && (!cand_in.found || (prio_reg > cand_in.prio)))
        begin
            cand_next.found = 1'b1;
            cand_next.prio  = prio_reg;
            cand_next.idx   = idx;
        end
    end

    assign cand_out = cand_reg;

    always_comb
    begin
        stat = '0;
        if (is_cur)
        begin
            stat.live     = live;
            stat.last     = valid_reg && (rem_reg == pps_pkg::WORK_W'(1));
            stat.wait_cnt = wait_reg;
            stat.burst    = burst_reg;
        end
    end

endmodule
